### rtl/bfla_pkg.sv
// ----------------------------------------------------------------------------
// bfla_pkg
// Shared widths, codes and controller/datapath types for the linked
// free-list block allocator.
// ----------------------------------------------------------------------------
package bfla_pkg;

    // field widths
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;

    // largest volume that a block index can address
    localparam int IDX_SPAN = 1024;

    // defaults
    localparam int MAX_BLOCKS_DEF = 1024;
    localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;
    localparam logic [CNT_W-1:0] BLOCK_COUNT_MIN = 11'd2;

    // request kinds
    typedef enum logic [FUNC_W-1:0] {
        FUNC_FORMAT = 2'd0,
        FUNC_ALLOC  = 2'd1,
        FUNC_FREE   = 2'd2
    } func_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK          = 2'd0,
        STAT_EMPTY       = 2'd1,
        STAT_UNFORMATTED = 2'd2,
        STAT_BAD_INDEX   = 2'd3
    } status_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FMT,
        ST_ALLOC,
        ST_DONE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    fmt_start;
        logic    fmt_step;
        logic    fmt_finish;
        logic    alloc_pop;
        logic    free_push;
        logic    res_set;
        status_t res_status;
        logic    out_load;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic formatted;
        logic head_zero;
        logic free_bad;
        logic fmt_last;
        logic out_free;
    } dp_stat_t;

endpackage

### rtl/bfla_req_if.sv
// ----------------------------------------------------------------------------
// bfla_req_if
// Request channel: valid/ready handshake with request kind and block index.
// ----------------------------------------------------------------------------
interface bfla_req_if;

    logic                        valid;
    logic                        ready;
    logic [bfla_pkg::FUNC_W-1:0] func;
    logic [bfla_pkg::IDX_W-1:0]  block;

    modport source (output valid, output func, output block, input ready);
    modport sink   (input valid, input func, input block, output ready);

endinterface

### rtl/bfla_rsp_if.sv
// ----------------------------------------------------------------------------
// bfla_rsp_if
// Result channel: valid/ready handshake with granted block, count and status.
// ----------------------------------------------------------------------------
interface bfla_rsp_if;

    logic                        valid;
    logic                        ready;
    logic [bfla_pkg::IDX_W-1:0]  granted_block;
    logic [bfla_pkg::IDX_W-1:0]  free_count;
    logic [bfla_pkg::STAT_W-1:0] status;

    modport source (output valid, output granted_block, output free_count,
                    output status, input ready);
    modport sink   (input valid, input granted_block, input free_count,
                    input status, output ready);

endinterface

### rtl/bfla_ram.sv
// ----------------------------------------------------------------------------
// bfla_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bfla_ram #(
    parameter int WIDTH = bfla_pkg::IDX_W,
    parameter int DEPTH = bfla_pkg::MAX_BLOCKS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bfla_ctrl.sv
// ----------------------------------------------------------------------------
// bfla_ctrl
// Controller: sequences format, allocate and free requests and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module bfla_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [bfla_pkg::FUNC_W-1:0] in_func,
    output logic                        in_ready,
    input  bfla_pkg::dp_stat_t          stat,
    output bfla_pkg::dp_cmd_t           cmd
);

    bfla_pkg::state_t state_reg;
    bfla_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfla_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.res_status = bfla_pkg::STAT_OK;

        case (state_reg)
            bfla_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = bfla_pkg::ST_DONE;
                    case (in_func)
                        bfla_pkg::FUNC_FORMAT:
                        begin
                            cmd.fmt_start = 1'b1;
                            state_next    = bfla_pkg::ST_FMT;
                        end
                        bfla_pkg::FUNC_ALLOC:
                        begin
                            if (!stat.formatted)
                            begin
                                cmd.res_set    = 1'b1;
                                cmd.res_status = bfla_pkg::STAT_UNFORMATTED;
                            end
                            else if (stat.head_zero)
                            begin
                                cmd.res_set    = 1'b1;
                                cmd.res_status = bfla_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                // link of the head is read this cycle
                                state_next = bfla_pkg::ST_ALLOC;
                            end
                        end
                        bfla_pkg::FUNC_FREE:
                        begin
                            cmd.res_set = 1'b1;
                            if (!stat.formatted)
                            begin
                                cmd.res_status = bfla_pkg::STAT_UNFORMATTED;
                            end
                            else if (stat.free_bad)
                            begin
                                cmd.res_status = bfla_pkg::STAT_BAD_INDEX;
                            end
                            else
                            begin
                                cmd.free_push = 1'b1;
                            end
                        end
                        default:
                        begin
                            // unused request kind, no change
                            cmd.res_set = 1'b1;
                        end
                    endcase
                end
            end

            bfla_pkg::ST_FMT:
            begin
                cmd.fmt_step = 1'b1;
                if (stat.fmt_last)
                begin
                    cmd.fmt_finish = 1'b1;
                    cmd.res_set    = 1'b1;
                    state_next     = bfla_pkg::ST_DONE;
                end
            end

            bfla_pkg::ST_ALLOC:
            begin
                cmd.alloc_pop = 1'b1;
                state_next    = bfla_pkg::ST_DONE;
            end

            bfla_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = bfla_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bfla_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/bfla_dpath.sv
// ----------------------------------------------------------------------------
// bfla_dpath
// Datapath: block count register, list head, free total, format counter,
// link memory, result and output registers.
// ----------------------------------------------------------------------------
module bfla_dpath #(
    parameter int MAX_BLOCKS = bfla_pkg::MAX_BLOCKS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [bfla_pkg::CNT_W-1:0]  cfg_wdata,
    input  logic [bfla_pkg::IDX_W-1:0]  in_block,
    input  bfla_pkg::dp_cmd_t           cmd,
    output bfla_pkg::dp_stat_t          stat,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bfla_pkg::IDX_W-1:0]  out_granted,
    output logic [bfla_pkg::IDX_W-1:0]  out_count,
    output logic [bfla_pkg::STAT_W-1:0] out_status
);

    localparam int AW      = $clog2(MAX_BLOCKS);
    localparam int LIM_INT = (MAX_BLOCKS > bfla_pkg::IDX_SPAN) ?
                             bfla_pkg::IDX_SPAN : MAX_BLOCKS;
    localparam logic [bfla_pkg::CNT_W-1:0] SIZE_LIM = bfla_pkg::CNT_W'(LIM_INT);

    logic [bfla_pkg::CNT_W-1:0] block_count_reg;
    logic [bfla_pkg::CNT_W-1:0] vol_size_reg;
    logic [bfla_pkg::IDX_W-1:0] head_reg;
    logic [bfla_pkg::IDX_W-1:0] total_reg;
    logic                       formatted_reg;
    logic [bfla_pkg::IDX_W-1:0] fmt_idx_reg;
    logic [bfla_pkg::IDX_W-1:0] res_granted_reg;
    bfla_pkg::status_t          res_status_reg;
    logic                       out_valid_reg;
    logic [bfla_pkg::IDX_W-1:0] out_granted_reg;
    logic [bfla_pkg::IDX_W-1:0] out_count_reg;
    bfla_pkg::status_t          out_status_reg;

    logic [bfla_pkg::CNT_W-1:0] size_clamped;
    logic [bfla_pkg::CNT_W-1:0] fmt_idx_inc;
    logic [bfla_pkg::CNT_W-1:0] total_inc;
    logic [bfla_pkg::CNT_W-1:0] block_ext;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [bfla_pkg::IDX_W-1:0] ram_wdata;
    logic [bfla_pkg::IDX_W-1:0] ram_rdata;

    // volume size clamped to the supported range at format
    always_comb
    begin
        if (block_count_reg < bfla_pkg::BLOCK_COUNT_MIN)
        begin
            size_clamped = bfla_pkg::BLOCK_COUNT_MIN;
        end
        else if (block_count_reg > SIZE_LIM)
        begin
            size_clamped = SIZE_LIM;
        end
        else
        begin
            size_clamped = block_count_reg;
        end
    end

    // status towards the controller
    assign fmt_idx_inc = {1'b0, fmt_idx_reg} + 1'b1;
    assign total_inc   = {1'b0, total_reg} + 1'b1;
    assign block_ext   = {1'b0, in_block};

    assign stat.formatted = formatted_reg;
    assign stat.head_zero = (head_reg == '0);
    assign stat.free_bad  = (in_block == '0) || (block_ext >= vol_size_reg)
                            || (total_inc >= vol_size_reg);
    assign stat.fmt_last  = (fmt_idx_inc == vol_size_reg);
    assign stat.out_free  = !out_valid_reg || out_ready;

    // link memory write: chain step during format, push on free
    assign ram_we    = cmd.fmt_step || cmd.free_push;
    assign ram_waddr = cmd.fmt_step ? AW'(fmt_idx_reg) : AW'(in_block);
    always_comb
    begin
        if (cmd.fmt_step)
        begin
            ram_wdata = stat.fmt_last ? '0 : fmt_idx_inc[bfla_pkg::IDX_W-1:0];
        end
        else
        begin
            ram_wdata = head_reg;
        end
    end

    // link memory, read address follows the list head
    bfla_ram #(
        .WIDTH (bfla_pkg::IDX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (AW'(head_reg)),
        .rdata (ram_rdata)
    );

    // list state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= bfla_pkg::BLOCK_COUNT_RST;
            vol_size_reg    <= '0;
            head_reg        <= '0;
            total_reg       <= '0;
            formatted_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                block_count_reg <= cfg_wdata;
            end
            if (cmd.fmt_start)
            begin
                vol_size_reg <= size_clamped;
            end
            if (cmd.fmt_finish)
            begin
                head_reg      <= bfla_pkg::IDX_W'(1);
                total_reg     <= bfla_pkg::IDX_W'(vol_size_reg - 1'b1);
                formatted_reg <= 1'b1;
            end
            if (cmd.alloc_pop)
            begin
                head_reg <= ram_rdata;
                if (total_reg != '0)
                begin
                    total_reg <= total_reg - 1'b1;
                end
            end
            if (cmd.free_push)
            begin
                head_reg  <= in_block;
                total_reg <= total_inc[bfla_pkg::IDX_W-1:0];
            end
            // output register valid
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // format counter, result and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.fmt_start)
        begin
            fmt_idx_reg <= bfla_pkg::IDX_W'(1);
        end
        else if (cmd.fmt_step)
        begin
            fmt_idx_reg <= fmt_idx_inc[bfla_pkg::IDX_W-1:0];
        end
        if (cmd.alloc_pop)
        begin
            res_granted_reg <= head_reg;
            res_status_reg  <= bfla_pkg::STAT_OK;
        end
        else if (cmd.res_set)
        begin
            res_granted_reg <= '0;
            res_status_reg  <= cmd.res_status;
        end
        if (cmd.out_load)
        begin
            out_granted_reg <= res_granted_reg;
            out_count_reg   <= total_reg;
            out_status_reg  <= res_status_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_granted = out_granted_reg;
    assign out_count   = out_count_reg;
    assign out_status  = out_status_reg;

endmodule

### rtl/block_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// block_free_list_allocator_core
// Linked free-list allocator over the blocks of one volume.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one request: func (format, allocate, free) and the
//   block to release on a free. rsp carries one result per request:
//   granted_block, free_count after the request and status.
//   cfg_we/cfg_wdata write block_count; write it only while the block is idle.
//   Format latches block_count, clamped to 2 .. min(MAX_BLOCKS, 1024).
// Sequencing (request accept to result in a free output register):
//   free, rejected and unused requests go from accept straight to the result
//   state; allocate passes through one registered read of the link memory;
//   format does one link memory write for each of blocks 1 .. n-1, n the
//   clamped block count. The next request is accepted in the cycle after the
//   result is loaded; one request is in progress at a time.
// Reset: list empty and not formatted, block_count 1024; link memory
//   contents are not cleared, format writes every link it will use.
// Stall: a result waits in the output register while rsp.ready is low;
//   a further request is still accepted and its result held back until
//   the output register is free.
// ----------------------------------------------------------------------------
module block_free_list_allocator_core #(
    parameter int MAX_BLOCKS = bfla_pkg::MAX_BLOCKS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [bfla_pkg::CNT_W-1:0] cfg_wdata,
    bfla_req_if.sink                   req,
    bfla_rsp_if.source                 rsp
);

    bfla_pkg::dp_cmd_t  cmd;
    bfla_pkg::dp_stat_t stat;

    // request sequencing
    bfla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_func  (req.func),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // list state, link memory and output register
    bfla_dpath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_block    (req.block),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .out_granted (rsp.granted_block),
        .out_count   (rsp.free_count),
        .out_status  (rsp.status)
    );

endmodule

### verif/bfla_answer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bfla_answer_checker
// Watches the request and result channels of the free-list allocator, keeps
// its own copy of the link memory, head, free count and block count, works
// out the answer to every accepted request and compares each returned answer
// field by field with the oldest one still awaited.
// ----------------------------------------------------------------------------
module bfla_answer_checker
    import bfla_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    bfla_req_if              req,
    bfla_rsp_if              rsp,
    output int               fail_count,
    output int               pending
);

    // one answer as the result channel carries it
    typedef struct packed {
        logic [IDX_W-1:0] granted;
        logic [IDX_W-1:0] count;
        status_t          status;
    } alloc_answer_t;

    // allocator image
    logic [IDX_W-1:0] link_mem [IDX_SPAN];
    logic [IDX_W-1:0] head;
    int               free_total;
    int               vol_size;
    logic             formatted;
    logic [CNT_W-1:0] count_reg;

    alloc_answer_t awaited_answers[$];
    alloc_answer_t want_ans;

    // apply one request to the image and return its answer
    function automatic alloc_answer_t predict_answer(input logic [FUNC_W-1:0] fn,
                                                     input logic [IDX_W-1:0]  blk);
        alloc_answer_t ans;
        int            n;
        int            lim;
        ans.granted = '0;
        ans.status  = STAT_OK;
        case (fn)
            FUNC_FORMAT:
            begin
                // clamp the count, then chain 1 .. n-1
                lim = (MAX_BLOCKS > IDX_SPAN) ? IDX_SPAN : MAX_BLOCKS;
                n   = int'(count_reg);
                if (n < 2)
                    n = 2;
                if (n > lim)
                    n = lim;
                for (int i = 1; i + 1 < n; i++)
                    link_mem[i] = IDX_W'(i + 1);
                link_mem[n-1] = '0;
                vol_size   = n;
                head       = IDX_W'(1);
                free_total = n - 1;
                formatted  = 1'b1;
            end
            FUNC_ALLOC:
            begin
                if (!formatted)
                    ans.status = STAT_UNFORMATTED;
                else if (head == '0)
                    ans.status = STAT_EMPTY;
                else
                begin
                    // pop the head
                    ans.granted = head;
                    head        = link_mem[head];
                    if (free_total > 0)
                        free_total--;
                end
            end
            FUNC_FREE:
            begin
                if (!formatted)
                    ans.status = STAT_UNFORMATTED;
                else if (blk == '0 || int'(blk) >= vol_size || free_total + 1 >= vol_size)
                    ans.status = STAT_BAD_INDEX;
                else
                begin
                    // push as new head, repeated frees included
                    link_mem[blk] = head;
                    head          = blk;
                    free_total++;
                end
            end
            default:
                ;
        endcase
        ans.count = IDX_W'(free_total);
        return ans;
    endfunction

    // result check first, so a result never meets its own request's answer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaited_answers.delete();
            head       = '0;
            free_total = 0;
            vol_size   = 0;
            formatted  = 1'b0;
            count_reg  = BLOCK_COUNT_RST;
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_answers.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: granted %0d free count %0d status %0d",
                                 rsp.granted_block, rsp.free_count, rsp.status);
                    fail_count++;
                end
                else
                begin
                    want_ans = awaited_answers.pop_front();
                    if (rsp.granted_block !== want_ans.granted ||
                        rsp.free_count !== want_ans.count ||
                        rsp.status !== want_ans.status)
                    begin
                        if (fail_count < 10)
                            $display({"result mismatch: granted exp %0d got %0d, ",
                                      "free count exp %0d got %0d, status exp %0d got %0d"},
                                     want_ans.granted, rsp.granted_block,
                                     want_ans.count, rsp.free_count,
                                     want_ans.status, rsp.status);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
                awaited_answers.push_back(predict_answer(req.func, req.block));
            if (cfg_we)
                count_reg = cfg_wdata;
            pending = awaited_answers.size();
        end
    end

endmodule

### verif/tb_block_free_list_allocator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_block_free_list_allocator_core
// Drives directed and random format, allocate, free and unused requests into
// the allocator over several block counts, with bursty requests and a
// stalling result side; the answer checker beside the block does the
// comparison and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_block_free_list_allocator_core;

    import bfla_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 30;
    localparam int PHASES         = 8;
    localparam int PHASE_REQUESTS = 55;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int burst_left;
    int vol_now;
    int idle_cycles;
    int ready_mode;
    int ready_left;

    bfla_req_if req_ch ();
    bfla_rsp_if rsp_ch ();

    block_free_list_allocator_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    bfla_answer_checker answer_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // result side stalls in modes: open, random, ready only when the countdown is a multiple of five
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 2);
            ready_left = $urandom_range(4, 40);
        end
        ready_left--;
        case (ready_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ch.ready <= (ready_left % 5 == 0);
        endcase
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // one request, in bursts with random gaps between them
    task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [IDX_W-1:0] blk);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1, 2:    gap = $urandom_range(1, 4);
                default: gap = $urandom_range(5, 25);
            endcase
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= fn;
        req_ch.block <= blk;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        burst_left--;
    endtask

    // stop requesting and wait for every answer
    task automatic wait_for_answers();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    // block count write while idle
    task automatic set_block_count(input logic [CNT_W-1:0] value);
        wait_for_answers();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        vol_now = int'(value);
        if (vol_now < 2)
            vol_now = 2;
        if (vol_now > IDX_SPAN)
            vol_now = IDX_SPAN;
    endtask

    // random request mix: mostly in-range allocate and free
    task automatic random_request(input int alloc_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            send_request(FUNC_FORMAT, IDX_W'($urandom_range(0, 1023)));
        else if (pick < 7)
            send_request(FUNC_UNUSED, IDX_W'($urandom_range(0, 1023)));
        else if (pick < 15)
            send_request(FUNC_FREE, IDX_W'($urandom_range(0, 1023)));
        else if (pick < 15 + alloc_pct * 85 / 100)
            send_request(FUNC_ALLOC, IDX_W'($urandom_range(0, 1023)));
        else
            send_request(FUNC_FREE, IDX_W'($urandom_range(1, vol_now - 1)));
    endtask

    // stimulus and verdict
    initial
    begin
        int count_val;
        int alloc_pct;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        req_ch.valid <= 1'b0;
        req_ch.func  <= FUNC_FORMAT;
        req_ch.block <= '0;
        burst_left  = 0;
        vol_now     = IDX_SPAN;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // before any format, then a format at the reset count
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_FREE, 10'd1023);
        send_request(FUNC_UNUSED, 10'd1023);
        send_request(FUNC_FORMAT, '0);
        send_request(FUNC_FREE, 10'd1023);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_FREE, '0);
        send_request(FUNC_FREE, 10'd1023);
        send_request(FUNC_UNUSED, '0);

        // count below range: empty list, out-of-range and full-list frees
        set_block_count('0);
        send_request(FUNC_FORMAT, '0);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_FREE, 10'd2);
        send_request(FUNC_FREE, 10'd1);
        send_request(FUNC_FREE, 10'd1);

        // count above range
        set_block_count(11'd2047);
        send_request(FUNC_FORMAT, '0);
        send_request(FUNC_FREE, 10'd512);

        // small volume and a re-format
        set_block_count(11'd5);
        send_request(FUNC_FORMAT, '0);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_ALLOC, '0);
        send_request(FUNC_FREE, 10'd3);
        send_request(FUNC_FORMAT, '0);

        // random phases, mostly small volumes
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       count_val = 1;
                1:       count_val = 2047;
                2:       count_val = $urandom_range(0, 2047);
                3:       count_val = 2;
                default: count_val = $urandom_range(3, 40);
            endcase
            alloc_pct = $urandom_range(30, 70);
            set_block_count(CNT_W'(count_val));
            send_request(FUNC_FORMAT, IDX_W'($urandom_range(0, 1023)));
            for (int k = 0; k < PHASE_REQUESTS; k++)
                random_request(alloc_pct);
        end

        wait_for_answers();
        repeat (END_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
